/* hw/rtl/hhlv_pkg.sv */
`default_nettype none

package hhlv_pkg;

  // Configuration port geometry.
  localparam int unsigned ApbAddrW = 4;
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned LimitW   = 16;
  localparam int unsigned FieldW   = 16;

  // Register indexes (byte address is four times the index).
  localparam logic [1:0] RegMaxLine  = 2'd0;
  localparam logic [1:0] RegMaxName  = 2'd1;
  localparam logic [1:0] RegMaxValue = 2'd2;

  localparam logic [LimitW-1:0] MaxLineReset  = 16'd8192;
  localparam logic [LimitW-1:0] MaxNameReset  = 16'd256;
  localparam logic [LimitW-1:0] MaxValueReset = 16'd8192;

  // Characters of interest.
  localparam logic [7:0] ChColon = 8'h3a;
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChVisLo = 8'h20;
  localparam logic [7:0] ChVisHi = 8'h7e;

  typedef enum logic [1:0] {
    StComplete   = 2'd0,
    StIncomplete = 2'd1,
    StInvalid    = 2'd2,
    StTooLarge   = 2'd3
  } status_e;

  typedef struct packed {
    logic [LimitW-1:0] max_line_bytes;
    logic [LimitW-1:0] max_name_bytes;
    logic [LimitW-1:0] max_value_bytes;
  } cfg_t;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       byte_present;
    logic       span_end;
  } item_t;

  function automatic logic is_token(input logic [7:0] b);
    logic r;
    case (b) inside
      [8'h30:8'h39], [8'h41:8'h5a], [8'h61:8'h7a],
      8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2a, 8'h2b,
      8'h2d, 8'h2e, 8'h5e, 8'h5f, 8'h60, 8'h7c, 8'h7e: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return (b == ChSpace) || (b == ChTab);
  endfunction

  function automatic logic is_value(input logic [7:0] b);
    return (b == ChTab) || ((b >= ChVisLo) && (b <= ChVisHi));
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/hhlv_intf.sv */
`default_nettype none

interface hhlv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] line_byte;
  logic       byte_present;
  logic       span_end;

  modport source (output valid, line_byte, byte_present, span_end, input ready);
  modport sink   (input valid, line_byte, byte_present, span_end, output ready);
endinterface

interface hhlv_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] fault_offset;
  logic [15:0] name_size;
  logic [15:0] value_offset;
  logic [15:0] value_length;
  logic [15:0] line_used;

  modport source (output valid, status, fault_offset, name_size, value_offset,
                  value_length, line_used, input ready);
  modport sink   (input valid, status, fault_offset, name_size, value_offset,
                  value_length, line_used, output ready);
endinterface

`default_nettype wire

/* hw/rtl/hhlv_cfg.sv */
`default_nettype none

// Limit registers behind the APB-style port.
module hhlv_cfg (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [hhlv_pkg::ApbAddrW-1:0]   paddr,
  input  wire logic [hhlv_pkg::ApbDataW-1:0]   pwdata,
  output logic      [hhlv_pkg::ApbDataW-1:0]   prdata,
  output logic                                 pready,
  output hhlv_pkg::cfg_t                       cfg_o
);

  hhlv_pkg::cfg_t cfg_q;
  logic           wr_en;
  logic [1:0]     reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_line_bytes  <= hhlv_pkg::MaxLineReset;
      cfg_q.max_name_bytes  <= hhlv_pkg::MaxNameReset;
      cfg_q.max_value_bytes <= hhlv_pkg::MaxValueReset;
    end else if (wr_en) begin
      unique case (reg_idx)
        hhlv_pkg::RegMaxLine:  cfg_q.max_line_bytes  <= pwdata[hhlv_pkg::LimitW-1:0];
        hhlv_pkg::RegMaxName:  cfg_q.max_name_bytes  <= pwdata[hhlv_pkg::LimitW-1:0];
        hhlv_pkg::RegMaxValue: cfg_q.max_value_bytes <= pwdata[hhlv_pkg::LimitW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      hhlv_pkg::RegMaxLine:  prdata = 32'(cfg_q.max_line_bytes);
      hhlv_pkg::RegMaxName:  prdata = 32'(cfg_q.max_name_bytes);
      hhlv_pkg::RegMaxValue: prdata = 32'(cfg_q.max_value_bytes);
      default:               prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/hhlv_in_stage.sv */
`default_nettype none

// Input register. It refills in the same cycle that its item moves on.
module hhlv_in_stage (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  hhlv_in_if.sink        in_i,
  input  wire logic      stall_i,
  output hhlv_pkg::item_t item_o,
  output logic           item_valid_o
);

  logic            valid_q;
  hhlv_pkg::item_t item_q;
  logic            load;

  assign load      = !valid_q || !stall_i;
  assign in_i.ready = load;
  assign item_o       = item_q;
  assign item_valid_o = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      item_q  <= '0;
    end else if (load) begin
      valid_q             <= in_i.valid;
      item_q.line_byte    <= in_i.line_byte;
      item_q.byte_present <= in_i.byte_present;
      item_q.span_end     <= in_i.span_end;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/hhlv_core.sv */
`default_nettype none

// Parse state machine, result register. One item per cycle unless stalled.
module hhlv_core #(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire hhlv_pkg::cfg_t  cfg_i,
  input  wire hhlv_pkg::item_t item_i,
  input  wire logic            item_valid_i,
  output logic                 stall_o,
  hhlv_out_if.source           out_o
);

  localparam int unsigned CmpW = (OFFSET_BITS > hhlv_pkg::LimitW) ?
                                 OFFSET_BITS : hhlv_pkg::LimitW;
  localparam int unsigned FW   = hhlv_pkg::FieldW;

  typedef logic [OFFSET_BITS-1:0] off_t;

  typedef enum logic [2:0] {
    PhName,
    PhOws,
    PhValue,
    PhLf,
    PhDiscard
  } phase_e;

  phase_e phase_q, phase_d;
  off_t   off_q, off_d;
  off_t   nlen_q, nlen_d;
  off_t   vbeg_q, vbeg_d;
  off_t   vstop_q, vstop_d;

  logic                  out_valid_q;
  hhlv_pkg::status_e     status_q, res_status;
  logic [FW-1:0]         err_q, nlen_out_q, voff_q, vlen_q, used_q;
  logic [FW-1:0]         res_err, res_nlen, res_voff, res_vlen, res_used;
  logic                  res_load;

  logic       take;
  logic [7:0] b;
  logic       fail, done;
  hhlv_pkg::status_e fail_st;
  off_t       vb_eff, off_next, span;

  assign stall_o = out_valid_q && !out_o.ready;
  assign take    = item_valid_i && !stall_o;
  assign b       = item_i.line_byte;

  always_comb begin
    phase_d    = phase_q;
    off_d      = off_q;
    nlen_d     = nlen_q;
    vbeg_d     = vbeg_q;
    vstop_d    = vstop_q;
    res_load   = 1'b0;
    res_status = hhlv_pkg::StComplete;
    res_err    = '0;
    res_nlen   = '0;
    res_voff   = '0;
    res_vlen   = '0;
    res_used   = '0;
    fail       = 1'b0;
    done       = 1'b0;
    fail_st    = hhlv_pkg::StInvalid;
    vb_eff     = vbeg_q;
    off_next   = off_q;
    span       = '0;

    if (take && (phase_q == PhDiscard)) begin
      if (item_i.span_end) begin
        phase_d = PhName;
        off_d   = '0;
        nlen_d  = '0;
        vbeg_d  = '0;
        vstop_d = '0;
      end
    end else if (take) begin
      if (item_i.byte_present) begin
        if (CmpW'(off_q) >= CmpW'(cfg_i.max_line_bytes)) begin
          fail    = 1'b1;
          fail_st = hhlv_pkg::StTooLarge;
        end else begin
          unique case (phase_q)
            PhName: begin
              if (b == hhlv_pkg::ChColon) begin
                if (off_q == '0) begin
                  fail = 1'b1;
                end else begin
                  nlen_d  = off_q;
                  phase_d = PhOws;
                end
              end else if (!hhlv_pkg::is_token(b)) begin
                fail = 1'b1;
              end else if (CmpW'(off_q) >= CmpW'(cfg_i.max_name_bytes)) begin
                fail    = 1'b1;
                fail_st = hhlv_pkg::StTooLarge;
              end
            end
            PhOws, PhValue: begin
              if (!((phase_q == PhOws) && hhlv_pkg::is_blank(b))) begin
                if (phase_q == PhOws) begin
                  // First value byte: the value span opens here.
                  vb_eff  = off_q;
                  vbeg_d  = off_q;
                  vstop_d = off_q;
                  phase_d = PhValue;
                end
                span = off_q - vb_eff;
                if (b == hhlv_pkg::ChCr) begin
                  phase_d = PhLf;
                end else if ((b == hhlv_pkg::ChLf) || !hhlv_pkg::is_value(b)) begin
                  fail = 1'b1;
                end else if (!hhlv_pkg::is_blank(b)) begin
                  if (CmpW'(span) >= CmpW'(cfg_i.max_value_bytes)) begin
                    fail    = 1'b1;
                    fail_st = hhlv_pkg::StTooLarge;
                  end else begin
                    vstop_d = off_q + off_t'(1);
                  end
                end
              end
            end
            PhLf: begin
              if (b == hhlv_pkg::ChLf) begin
                done = 1'b1;
              end else begin
                fail = 1'b1;
              end
            end
            default: fail = 1'b1;
          endcase
        end
        if (!fail && !done) begin
          off_next = off_q + off_t'(1);
        end
      end

      if (done || fail || item_i.span_end) begin
        res_load = 1'b1;
        phase_d  = PhName;
        off_d    = '0;
        nlen_d   = '0;
        vbeg_d   = '0;
        vstop_d  = '0;
        if (done) begin
          res_status = hhlv_pkg::StComplete;
          res_nlen   = FW'(nlen_q);
          res_voff   = FW'(vbeg_q);
          res_vlen   = FW'(off_t'(vstop_q - vbeg_q));
          res_used   = FW'(off_t'(off_q + off_t'(1)));
        end else if (fail) begin
          res_status = fail_st;
          res_err    = FW'(off_q);
          if (!item_i.span_end) begin
            phase_d = PhDiscard;
          end
        end else begin
          res_status = (CmpW'(off_next) >= CmpW'(cfg_i.max_line_bytes)) ?
                       hhlv_pkg::StTooLarge : hhlv_pkg::StIncomplete;
          res_err    = FW'(off_next);
        end
      end else begin
        off_d = off_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhName;
      off_q       <= '0;
      nlen_q      <= '0;
      vbeg_q      <= '0;
      vstop_q     <= '0;
      out_valid_q <= 1'b0;
      status_q    <= hhlv_pkg::StComplete;
      err_q       <= '0;
      nlen_out_q  <= '0;
      voff_q      <= '0;
      vlen_q      <= '0;
      used_q      <= '0;
    end else begin
      phase_q <= phase_d;
      off_q   <= off_d;
      nlen_q  <= nlen_d;
      vbeg_q  <= vbeg_d;
      vstop_q <= vstop_d;
      if (res_load) begin
        out_valid_q <= 1'b1;
        status_q    <= res_status;
        err_q       <= res_err;
        nlen_out_q  <= res_nlen;
        voff_q      <= res_voff;
        vlen_q      <= res_vlen;
        used_q      <= res_used;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = status_q;
  assign out_o.fault_offset = err_q;
  assign out_o.name_size    = nlen_out_q;
  assign out_o.value_offset = voff_q;
  assign out_o.value_length = vlen_q;
  assign out_o.line_used    = used_q;

  // A result never overwrites one that the sink has not taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> !res_load)
    else $error("result register overwritten while stalled");

  // Discarding bytes after an error produces no result.
  a_discard_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && (phase_q == PhDiscard)) |-> !res_load)
    else $error("result produced while discarding");

  // Every result restarts the line at offset zero.
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |=> (off_q == '0))
    else $error("offset not cleared after a result");

  // The discard phase is only entered through a restart.
  a_discard_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhDiscard) |-> (off_q == '0))
    else $error("discard phase with a nonzero offset");

  // Past the colon the recorded name is never empty.
  a_name_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((phase_q == PhOws) || (phase_q == PhValue) || (phase_q == PhLf)) |-> (nlen_q != '0))
    else $error("empty name recorded past the colon");

endmodule

`default_nettype wire

/* hw/rtl/http_header_line_validator.sv */
`default_nettype none

// HTTP header field line checker. Each request on in_i carries one byte of a
// "name: value CRLF" line (or a bare end marker when byte_present is low),
// and span_end marks the last item the caller supplies. The block accepts one
// request every clock cycle while no result waits at a stalled sink. Each
// request is captured in the input register, and the parse step then turns
// it into a result that is loaded into the result register driving out_o.
// Throughput is set by that single parse step, which keeps all line state in
// registers and updates it once per byte. A result waiting at a stalled sink
// holds the input register, so the input register can take at most one more
// request before back-pressure reaches in_i. At most one result comes from
// each request: complete, incomplete, invalid or too large, with the byte
// offset of the failure. After an error the block drops requests up to and
// including the one that ends the span. The limits max_line_bytes,
// max_name_bytes and max_value_bytes sit at byte addresses 0, 4 and 8 of the
// APB-style port and should only be written while no line is in progress.
// Offsets count in OFFSET_BITS bits and wrap there; reported fields are the
// low 16 bits.
module http_header_line_validator #(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  hhlv_in_if.sink                             in_i,
  hhlv_out_if.source                          out_o,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [hhlv_pkg::ApbAddrW-1:0]  paddr,
  input  wire logic [hhlv_pkg::ApbDataW-1:0]  pwdata,
  output logic      [hhlv_pkg::ApbDataW-1:0]  prdata,
  output logic                                pready
);

  hhlv_pkg::cfg_t  cfg;
  hhlv_pkg::item_t item;
  logic            item_valid;
  logic            stall;

  // Limit registers.
  hhlv_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Input register, refilled whenever its item moves into the parse step.
  hhlv_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .stall_i      (stall),
    .item_o       (item),
    .item_valid_o (item_valid)
  );

  // Parse step, line state and result register.
  hhlv_core #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_i       (item),
    .item_valid_i (item_valid),
    .stall_o      (stall),
    .out_o        (out_o)
  );

endmodule

`default_nettype wire

/* bench/http_header_line_validator_test.sv */
`timescale 1ns / 1ps

module http_header_line_validator_test;

  // After the last expected result the bench waits DrainCycles more clock
  // edges, so that requests which produce no result (discarded bytes, empty
  // markers) have left the pipeline too.
  localparam int unsigned DrainCycles = 6;

  // Index past the end of the register list; writes to it must be ignored.
  localparam logic [1:0] RegSpare = 2'd3;

  // Punctuation that is allowed in a field name, next to letters and digits.
  localparam logic [7:0] TokenPunct [15] = '{
    8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2a, 8'h2b,
    8'h2d, 8'h2e, 8'h5e, 8'h5f, 8'h60, 8'h7c, 8'h7e
  };

  // Limit settings for the random traffic, the extremes among them. Small
  // limits make the name, value and line checks fire on short lines.
  localparam int NumSettings = 9;
  localparam logic [15:0] SetLine  [NumSettings] = '{
    16'd8192, 16'd65535, 16'd1, 16'd30, 16'd20, 16'd0, 16'd65535, 16'd40, 16'd12
  };
  localparam logic [15:0] SetName  [NumSettings] = '{
    16'd256, 16'd65535, 16'd1, 16'd6, 16'd12, 16'd0, 16'd3, 16'd65535, 16'd65535
  };
  localparam logic [15:0] SetValue [NumSettings] = '{
    16'd8192, 16'd65535, 16'd1, 16'd10, 16'd4, 16'd0, 16'd65535, 16'd0, 16'd65535
  };

  typedef enum logic [2:0] {
    PhName,
    PhOws,
    PhValue,
    PhLf,
    PhDiscard
  } line_phase_e;

  // One result of the block, in the order of the output fields.
  typedef struct packed {
    hhlv_pkg::status_e status;
    logic [15:0]       fault_offset;
    logic [15:0]       name_size;
    logic [15:0]       value_offset;
    logic [15:0]       value_length;
    logic [15:0]       line_used;
  } verdict_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [hhlv_pkg::ApbAddrW-1:0] paddr;
  logic [hhlv_pkg::ApbDataW-1:0] pwdata;
  logic [hhlv_pkg::ApbDataW-1:0] prdata;
  logic                          pready;

  hhlv_in_if  in_bus ();
  hhlv_out_if out_bus ();

  http_header_line_validator u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_bus),
    .out_o   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Our own copy of the limits and of the line state, kept in step with the
  // block by applying every accepted request to it.
  logic [15:0] lim_line;
  logic [15:0] lim_name;
  logic [15:0] lim_value;
  line_phase_e phase;
  logic [15:0] cur_off;
  logic [15:0] name_len;
  logic [15:0] val_begin;
  logic [15:0] val_stop;

  verdict_t    pending_verdicts [$];
  logic [7:0]  line_q [$];
  int unsigned error_count;
  int unsigned sent_items;
  int unsigned in_gap_max;
  int unsigned out_stall_max;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Line state predictor
  // ---------------------------------------------------------------------------

  function automatic bit is_tchar(input logic [7:0] b);
    if ((b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5a) ||
        (b >= 8'h61 && b <= 8'h7a)) begin
      return 1'b1;
    end
    foreach (TokenPunct[i]) begin
      if (b == TokenPunct[i]) begin
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic bit is_blank_byte(input logic [7:0] b);
    return (b == hhlv_pkg::ChSpace) || (b == hhlv_pkg::ChTab);
  endfunction

  function automatic bit is_value_byte(input logic [7:0] b);
    return (b == hhlv_pkg::ChTab) ||
           ((b >= hhlv_pkg::ChVisLo) && (b <= hhlv_pkg::ChVisHi));
  endfunction

  function automatic void restart_line();
    phase     = PhName;
    cur_off   = '0;
    name_len  = '0;
    val_begin = '0;
    val_stop  = '0;
  endfunction

  // Applies one present byte at the current offset. Returns 1 when the line
  // stops here, with the reason in st; otherwise the offset moves on.
  function automatic bit take_line_byte(input logic [7:0] b,
                                        output hhlv_pkg::status_e st);
    logic [15:0] off;
    logic [15:0] val_span;
    off = cur_off;
    st  = hhlv_pkg::StComplete;
    // The line limit is tested before anything is known about the byte.
    if (off >= lim_line) begin
      st = hhlv_pkg::StTooLarge;
      return 1'b1;
    end
    case (phase)
      PhName: begin
        if (b == hhlv_pkg::ChColon) begin
          // A colon with no name in front of it is not a field line.
          if (off == 16'd0) begin
            st = hhlv_pkg::StInvalid;
            return 1'b1;
          end
          name_len = off;
          phase    = PhOws;
        end else if (!is_tchar(b)) begin
          st = hhlv_pkg::StInvalid;
          return 1'b1;
        end else if (off >= lim_name) begin
          st = hhlv_pkg::StTooLarge;
          return 1'b1;
        end
      end
      PhOws, PhValue: begin
        // The first byte after the leading blanks opens the value, and is
        // itself handled as a value byte.
        if (phase == PhOws && !is_blank_byte(b)) begin
          val_begin = off;
          val_stop  = off;
          phase     = PhValue;
        end
        if (phase == PhValue) begin
          if (b == hhlv_pkg::ChCr) begin
            phase = PhLf;
          end else if (b == hhlv_pkg::ChLf || !is_value_byte(b)) begin
            st = hhlv_pkg::StInvalid;
            return 1'b1;
          end else if (!is_blank_byte(b)) begin
            // Only non-blank bytes extend the value, so trailing blanks are
            // trimmed and never count against the value limit.
            val_span = off - val_begin;
            if (val_span >= lim_value) begin
              st = hhlv_pkg::StTooLarge;
              return 1'b1;
            end
            val_stop = off + 16'd1;
          end
        end
      end
      PhLf: begin
        st = (b == hhlv_pkg::ChLf) ? hhlv_pkg::StComplete : hhlv_pkg::StInvalid;
        return 1'b1;
      end
      default: begin
        st = hhlv_pkg::StInvalid;
        return 1'b1;
      end
    endcase
    cur_off = off + 16'd1;
    return 1'b0;
  endfunction

  // Works out what one accepted request does; returns 1 with the result when
  // it causes one.
  function automatic bit line_step(input hhlv_pkg::item_t it, output verdict_t v);
    hhlv_pkg::status_e st;
    v = '0;
    // After an error everything up to the end of the span is dropped.
    if (phase == PhDiscard) begin
      if (it.span_end) begin
        restart_line();
      end
      return 1'b0;
    end
    if (it.byte_present && take_line_byte(it.line_byte, st)) begin
      v.status = st;
      if (st == hhlv_pkg::StComplete) begin
        v.name_size    = name_len;
        v.value_offset = val_begin;
        v.value_length = val_stop - val_begin;
        v.line_used    = cur_off + 16'd1;
        restart_line();
      end else begin
        v.fault_offset = cur_off;
        restart_line();
        // When the failing request closes the span there is nothing to skip.
        if (!it.span_end) begin
          phase = PhDiscard;
        end
      end
      return 1'b1;
    end
    // The span closed before the line did: the next offset decides whether
    // the line was merely short or had already run past its limit.
    if (it.span_end) begin
      v.status       = (cur_off >= lim_line) ? hhlv_pkg::StTooLarge :
                                               hhlv_pkg::StIncomplete;
      v.fault_offset = cur_off;
      restart_line();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Sends one request after a random pause, waits for it to be taken and
  // records the result it should cause. Valid is left high on return so that
  // back-to-back requests need no second assignment in the same time step.
  task automatic send_item(input logic [7:0] b, input logic present, input logic ends);
    int unsigned     gap;
    hhlv_pkg::item_t it;
    verdict_t        v;
    gap = (in_gap_max != 0) ? $urandom_range(0, in_gap_max) : 0;
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid        <= 1'b1;
    in_bus.line_byte    <= b;
    in_bus.byte_present <= present;
    in_bus.span_end     <= ends;
    do @(posedge clk_i); while (!in_bus.ready);
    sent_items++;
    it.line_byte    = b;
    it.byte_present = present;
    it.span_end     = ends;
    if (line_step(it, v)) begin
      pending_verdicts.push_back(v);
    end
  endtask

  task automatic emit_text(input string s, input bit end_last);
    for (int i = 0; i < s.len(); i++) begin
      send_item(s[i], 1'b1, end_last && (i == s.len() - 1));
    end
  endtask

  // Stops the requests and waits until the block has nothing left in flight.
  task automatic settle();
    in_bus.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure and the comparison with the oldest
  // outstanding prediction.
  // ---------------------------------------------------------------------------

  task automatic check_result();
    verdict_t want;
    verdict_t got;
    got.status       = hhlv_pkg::status_e'(out_bus.status);
    got.fault_offset = out_bus.fault_offset;
    got.name_size    = out_bus.name_size;
    got.value_offset = out_bus.value_offset;
    got.value_length = out_bus.value_length;
    got.line_used    = out_bus.line_used;
    if (pending_verdicts.size() == 0) begin
      $error("unexpected result: status %0d, fault_offset %0d", got.status,
             got.fault_offset);
      error_count++;
      return;
    end
    want = pending_verdicts.pop_front();
    if (got.status != want.status) begin
      $error("status: expected %0d, actual %0d", want.status, got.status);
      error_count++;
    end
    if (got.fault_offset != want.fault_offset) begin
      $error("fault_offset: expected %0d, actual %0d", want.fault_offset,
             got.fault_offset);
      error_count++;
    end
    if (got.name_size != want.name_size) begin
      $error("name_size: expected %0d, actual %0d", want.name_size,
             got.name_size);
      error_count++;
    end
    if (got.value_offset != want.value_offset) begin
      $error("value_offset: expected %0d, actual %0d", want.value_offset,
             got.value_offset);
      error_count++;
    end
    if (got.value_length != want.value_length) begin
      $error("value_length: expected %0d, actual %0d", want.value_length,
             got.value_length);
      error_count++;
    end
    if (got.line_used != want.line_used) begin
      $error("line_used: expected %0d, actual %0d", want.line_used,
             got.line_used);
      error_count++;
    end
  endtask

  initial begin : result_sink
    int unsigned stall;
    out_bus.ready <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      stall = (out_stall_max != 0) ? $urandom_range(0, out_stall_max) : 0;
      if (stall != 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!out_bus.valid);
      check_result();
    end
  end

  // ---------------------------------------------------------------------------
  // Register port
  // ---------------------------------------------------------------------------

  // Each transfer first waits for the next clock edge, so that psel never
  // gets two assignments in the step where the previous transfer ends.
  task automatic apb_write(input logic [1:0] idx, input logic [15:0] value);
    logic [15:0] junk;
    junk = 16'($urandom);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    // The upper half is noise: the limits are sixteen bits wide.
    pwdata  <= {junk, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      hhlv_pkg::RegMaxLine:  lim_line  = value;
      hhlv_pkg::RegMaxName:  lim_name  = value;
      hhlv_pkg::RegMaxValue: lim_value = value;
      default: ;
    endcase
  endtask

  task automatic apb_read(input logic [1:0] idx,
                          output logic [hhlv_pkg::ApbDataW-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    data     = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_registers();
    logic [hhlv_pkg::ApbDataW-1:0] data;
    apb_read(hhlv_pkg::RegMaxLine, data);
    if (data[15:0] != lim_line) begin
      $error("max_line_bytes: expected %0d, actual %0d", lim_line, data[15:0]);
      error_count++;
    end
    apb_read(hhlv_pkg::RegMaxName, data);
    if (data[15:0] != lim_name) begin
      $error("max_name_bytes: expected %0d, actual %0d", lim_name, data[15:0]);
      error_count++;
    end
    apb_read(hhlv_pkg::RegMaxValue, data);
    if (data[15:0] != lim_value) begin
      $error("max_value_bytes: expected %0d, actual %0d", lim_value, data[15:0]);
      error_count++;
    end
  endtask

  // Loads a full set of limits while the block is idle, pokes the unused
  // address as well, and reads everything back.
  task automatic load_limits(input logic [15:0] line_lim, input logic [15:0] name_lim,
                             input logic [15:0] value_lim);
    apb_write(hhlv_pkg::RegMaxLine, line_lim);
    apb_write(hhlv_pkg::RegMaxName, name_lim);
    apb_write(hhlv_pkg::RegMaxValue, value_lim);
    apb_write(RegSpare, 16'($urandom));
    check_registers();
  endtask

  // ---------------------------------------------------------------------------
  // Random line builder
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] rand_token();
    case ($urandom_range(0, 3))
      0:       return 8'(8'h30 + $urandom_range(0, 9));
      1:       return 8'(8'h41 + $urandom_range(0, 25));
      2:       return 8'(8'h61 + $urandom_range(0, 25));
      default: return TokenPunct[$urandom_range(0, 14)];
    endcase
  endfunction

  function automatic logic [7:0] rand_blank();
    return $urandom_range(0, 1) ? hhlv_pkg::ChSpace : hhlv_pkg::ChTab;
  endfunction

  function automatic logic [7:0] rand_value_byte();
    case ($urandom_range(0, 7))
      0:       return hhlv_pkg::ChSpace;
      1:       return hhlv_pkg::ChTab;
      default: return 8'($urandom_range(8'h21, 8'h7e));
    endcase
  endfunction

  // Sends the built line, now and then slipping in an empty marker that the
  // block must ignore.
  task automatic play_line(input bit end_last);
    for (int i = 0; i < line_q.size(); i++) begin
      if ($urandom_range(0, 15) == 0) begin
        send_item(8'($urandom), 1'b0, 1'b0);
      end
      send_item(line_q[i], 1'b1, end_last && (i == line_q.size() - 1));
    end
  endtask

  // Closes the span unless the line already brought the block back to the
  // start, so that every line begins at offset zero.
  task automatic close_line();
    if (!(phase == PhName && cur_off == 16'd0)) begin
      send_item(8'($urandom), 1'($urandom_range(0, 1)), 1'b1);
    end
  endtask

  // Mostly well-formed lines with random names, blanks and values; some with
  // one byte replaced or cut short, and some plain noise.
  task automatic random_line();
    int unsigned kind;
    int unsigned keep;
    kind = $urandom_range(0, 9);
    line_q.delete();
    if (kind == 9) begin
      repeat ($urandom_range(1, 8)) begin
        send_item(8'($urandom), 1'($urandom_range(0, 3) != 0),
                  1'($urandom_range(0, 3) == 0));
      end
      close_line();
      return;
    end
    repeat (($urandom_range(0, 7) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 10))
      line_q.push_back(rand_token());
    line_q.push_back(hhlv_pkg::ChColon);
    repeat ($urandom_range(0, 3)) line_q.push_back(rand_blank());
    repeat (($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 16))
      line_q.push_back(rand_value_byte());
    repeat ($urandom_range(0, 3)) line_q.push_back(rand_blank());
    line_q.push_back(hhlv_pkg::ChCr);
    line_q.push_back(hhlv_pkg::ChLf);
    if (kind == 7) begin
      line_q[$urandom_range(0, line_q.size() - 1)] = 8'($urandom);
    end else if (kind == 8) begin
      keep = $urandom_range(1, line_q.size() - 1);
      while (line_q.size() > keep) void'(line_q.pop_back());
    end
    play_line(1'($urandom_range(0, 1)));
    close_line();
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values, and a write to the unused address that must change nothing.
  task automatic test_register_access();
    check_registers();
    apb_write(RegSpare, 16'hffff);
    check_registers();
  endtask

  // Short hand-made lines under the reset limits: empty name, leading and
  // trailing blanks, empty value, bare LF, CR without LF, bad value and name
  // bytes, empty markers and a span that ends early.
  task automatic test_directed_lines();
    in_gap_max    = 8;
    out_stall_max = 8;
    send_item(hhlv_pkg::ChColon, 1'b1, 1'b1);
    emit_text("A:\t x \015\012", 1'b0);
    emit_text("~:\015\012", 1'b0);
    emit_text("z:\012", 1'b0);
    // The bare LF left the block discarding; only the span end brings it back.
    send_item(8'hff, 1'b0, 1'b1);
    emit_text("b:\015x", 1'b1);
    emit_text("c:\177", 1'b1);
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'h00, 1'b0, 1'b0);
    emit_text("q", 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    settle();
  endtask

  // Each limit firing on its own, first with tiny limits and then with every
  // limit at zero, where the first test of each must fail. No idling here.
  task automatic test_limit_cases();
    in_gap_max    = 0;
    out_stall_max = 0;
    load_limits(16'd6, 16'd2, 16'd2);
    emit_text("abc", 1'b1);
    emit_text("ab:xyz", 1'b1);
    emit_text("a:x\t\t\t", 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    emit_text("a: x  y", 1'b1);
    settle();
    load_limits(16'd0, 16'd0, 16'd0);
    send_item(8'h61, 1'b1, 1'b1);
    send_item(8'h00, 1'b0, 1'b1);
    settle();
  endtask

  // Random lines under each limit setting in turn, plus two drawn at random.
  // The idling of both sides is switched on and off between lines.
  task automatic test_random_traffic();
    int unsigned quota;
    for (int s = 0; s < NumSettings + 2; s++) begin
      if (s < NumSettings) begin
        load_limits(SetLine[s], SetName[s], SetValue[s]);
      end else begin
        load_limits(16'($urandom_range(1, 48)), 16'($urandom_range(1, 16)),
                    16'($urandom_range(1, 24)));
      end
      // Every setting gets about the same number of requests.
      quota = sent_items + 90;
      while (sent_items < quota) begin
        if ($urandom_range(0, 3) == 0) begin
          in_gap_max    = $urandom_range(0, 1) * 8;
          out_stall_max = $urandom_range(0, 1) * 8;
        end
        random_line();
      end
      settle();
    end
  endtask

  initial begin
    rst_ni              <= 1'b0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    in_bus.valid        <= 1'b0;
    in_bus.line_byte    <= '0;
    in_bus.byte_present <= 1'b0;
    in_bus.span_end     <= 1'b0;
    error_count   = 0;
    sent_items    = 0;
    in_gap_max    = 8;
    out_stall_max = 8;
    lim_line      = hhlv_pkg::MaxLineReset;
    lim_name      = hhlv_pkg::MaxNameReset;
    lim_value     = hhlv_pkg::MaxValueReset;
    restart_line();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_register_access();
    test_directed_lines();
    test_limit_cases();
    test_random_traffic();

    settle();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // A correct run takes a few tens of microseconds; this is far beyond it.
  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/hhlv_pkg.sv
hw/rtl/hhlv_intf.sv
hw/rtl/hhlv_cfg.sv
hw/rtl/hhlv_in_stage.sv
hw/rtl/hhlv_core.sv
hw/rtl/http_header_line_validator.sv
bench/http_header_line_validator_test.sv
